>>> sv/clt_pkg.sv
// Shared types, codes and keyword tables for the config line tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package clt_pkg;

    localparam int TOKEN_BUFFER_DEFAULT = 256;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_TOKEN,
        PH_DROP,
        PH_LEAD_COMMENT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_TOKEN_END,
        KIND_LINE_END,
        KIND_STREAM_END
    } result_kind_t;

    localparam logic [2:0] KW_NONE      = 3'd0;
    localparam logic [2:0] KW_ALL       = 3'd1;
    localparam logic [2:0] KW_SAMEUSER  = 3'd2;
    localparam logic [2:0] KW_SAMEGROUP = 3'd3;
    localparam logic [2:0] KW_SAMEROLE  = 3'd4;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam int KW_COUNT = 4;

    // Keyword text, right aligned: first character sits in the highest used byte.
    localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
        72'("all"), 72'("sameuser"), 72'("samegroup"), 72'("samerole")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd3, 4'd8, 4'd9, 4'd8};

    // Character i of keyword k; zero past the end.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] i);
        logic [3:0] len;
        logic [6:0] base;
        len = KW_LEN[k];
        base = '0;
        if (i < len) begin
            base = {len - i - 4'd1, 3'b000};
            return KW_TEXT[k][base +: 8];
        end
        return 8'h00;
    endfunction

    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   char_out;
        logic [7:0]   token_length;
        logic [2:0]   keyword_code;
        logic         was_quoted;
        logic         overflowed;
        logic         last_of_run;
    } result_t;

    // Up to two results produced by one processed byte.
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

>>> sv/clt_if.sv
// Handshake channels of the config line tokenizer: byte input and result output.
// No dependencies.
`timescale 1ns / 1ps

interface clt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       stream_end;

    modport source (output valid, output char_in, output stream_end, input ready);
    modport sink   (input valid, input char_in, input stream_end, output ready);
endinterface

interface clt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] char_out;
    logic [7:0] token_length;
    logic [2:0] keyword_code;
    logic       was_quoted;
    logic       overflowed;
    logic       last_of_run;

    modport source (output valid, output result_kind, output char_out,
                    output token_length, output keyword_code, output was_quoted,
                    output overflowed, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input char_out,
                    input token_length, input keyword_code, input was_quoted,
                    input overflowed, input last_of_run, output ready);
endinterface

>>> sv/clt_core.sv
// Tokenizer state and per-byte step logic; emits up to two results per byte.
// Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_core
    import clt_pkg::*;
#(
    parameter int TOKEN_BUFFER = TOKEN_BUFFER_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_in,
    input  logic       stream_end,
    output push_t      push
);

    localparam int CNT_W = $clog2(TOKEN_BUFFER - 1);
    localparam int EXT_W = (CNT_W > 8) ? CNT_W : 9;
    localparam logic [CNT_W-1:0] TOKEN_LIMIT = CNT_W'(TOKEN_BUFFER - 2);

    phase_t           phase_reg, phase_next;
    logic             inq_reg, inq_next;
    logic             pq_reg, pq_next;
    logic             aq_reg, aq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       kwl_reg, kwl_next;

    logic [CNT_W-1:0] cnt_inc;
    logic [3:0]       kwl_tracked;
    logic             is_nl, is_blank, is_hash, is_quote, is_comma;
    logic             do_clear, run_token;
    result_t          te_plain, te_comma, te_ov;

    function automatic result_t simple_res(input result_kind_t kind);
        result_t r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    function automatic result_t char_res(input logic [7:0] c);
        result_t r;
        r = '0;
        r.kind = KIND_CHAR;
        r.char_out = c;
        return r;
    endfunction

    function automatic result_t end_res(input logic [CNT_W-1:0] cnt, input logic [3:0] kwl,
                                        input logic aq, input logic ov);
        result_t          r;
        logic [EXT_W-1:0] cnt_ext;
        r = '0;
        cnt_ext = EXT_W'(cnt);
        r.kind = KIND_TOKEN_END;
        r.token_length = (cnt_ext > EXT_W'(255)) ? 8'hFF : cnt_ext[7:0];
        r.was_quoted = aq;
        r.overflowed = ov;
        if (!aq) begin
            priority if (kwl[0] && cnt == CNT_W'(KW_LEN[0])) r.keyword_code = KW_ALL;
            else if (kwl[1] && cnt == CNT_W'(KW_LEN[1]))     r.keyword_code = KW_SAMEUSER;
            else if (kwl[2] && cnt == CNT_W'(KW_LEN[2]))     r.keyword_code = KW_SAMEGROUP;
            else if (kwl[3] && cnt == CNT_W'(KW_LEN[3]))     r.keyword_code = KW_SAMEROLE;
            else                                             r.keyword_code = KW_NONE;
        end
        return r;
    endfunction

    always_comb
    begin
        is_nl    = (char_in == CH_NL);
        is_blank = (char_in == CH_SPACE) || (char_in == CH_TAB) || (char_in == CH_CR);
        is_hash  = (char_in == CH_HASH);
        is_quote = (char_in == CH_QUOTE);
        is_comma = (char_in == CH_COMMA);
        cnt_inc  = cnt_reg + CNT_W'(1);
        for (int k = 0; k < KW_COUNT; k++) begin
            kwl_tracked[k] = kwl_reg[k] && (cnt_reg < CNT_W'(KW_LEN[k]))
                             && (kw_char(2'(k), cnt_reg[3:0]) == char_in);
        end
        te_plain = end_res(cnt_reg, kwl_reg, aq_reg, 1'b0);
        te_comma = end_res(cnt_inc, kwl_tracked, aq_reg, 1'b0);
        te_ov    = end_res(cnt_reg, kwl_reg, aq_reg, 1'b1);
    end

    always_comb
    begin
        phase_next = phase_reg;
        inq_next   = inq_reg;
        pq_next    = pq_reg;
        aq_next    = aq_reg;
        cnt_next   = cnt_reg;
        kwl_next   = kwl_reg;
        push       = '0;
        do_clear   = 1'b0;
        run_token  = 1'b0;

        if (stream_end) begin
            if (phase_reg == PH_TOKEN || (phase_reg == PH_LEAD_COMMENT && aq_reg)) begin
                push.v0 = 1'b1;
                push.r0 = te_plain;
                push.v1 = 1'b1;
                push.r1 = simple_res(KIND_STREAM_END);
            end else begin
                push.v0 = 1'b1;
                push.r0 = simple_res(KIND_STREAM_END);
            end
            phase_next = PH_SKIP;
            do_clear = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (is_nl) begin
                        push.v0 = 1'b1;
                        push.r0 = simple_res(KIND_LINE_END);
                    end else if (!is_blank && !is_comma) begin
                        phase_next = PH_TOKEN;
                        run_token = 1'b1;
                    end
                end
                PH_TOKEN:
                begin
                    run_token = 1'b1;
                end
                PH_DROP:
                begin
                    if (is_nl) begin
                        phase_next = PH_SKIP;
                        do_clear = 1'b1;
                        push.v0 = 1'b1;
                        push.r0 = simple_res(KIND_LINE_END);
                    end
                end
                PH_LEAD_COMMENT:
                begin
                    if (is_nl) begin
                        push.v0 = 1'b1;
                        push.r0 = aq_reg ? te_plain : simple_res(KIND_LINE_END);
                        phase_next = PH_SKIP;
                        do_clear = 1'b1;
                    end
                end
                default: ;
            endcase

            if (run_token) begin
                priority if (is_nl) begin
                    push.v0 = 1'b1;
                    push.r0 = te_plain;
                    push.v1 = 1'b1;
                    push.r1 = simple_res(KIND_LINE_END);
                    phase_next = PH_SKIP;
                    do_clear = 1'b1;
                end else if (is_blank && !inq_reg) begin
                    push.v0 = 1'b1;
                    push.r0 = te_plain;
                    phase_next = PH_SKIP;
                    do_clear = 1'b1;
                end else if (is_hash && !inq_reg) begin
                    if (cnt_reg != '0) begin
                        push.v0 = 1'b1;
                        push.r0 = te_plain;
                        phase_next = PH_DROP;
                        do_clear = 1'b1;
                    end else begin
                        // comment before any stored text keeps the quote flag
                        phase_next = PH_LEAD_COMMENT;
                    end
                end else if (cnt_reg >= TOKEN_LIMIT) begin
                    push.v0 = 1'b1;
                    push.r0 = te_ov;
                    phase_next = PH_DROP;
                    do_clear = 1'b1;
                end else begin
                    if (!is_quote || pq_reg) begin
                        push.v0 = 1'b1;
                        push.r0 = char_res(char_in);
                        cnt_next = cnt_inc;
                        kwl_next = kwl_tracked;
                    end
                    if (is_comma && !inq_reg) begin
                        // comma is stored, then closes the token
                        push.v1 = 1'b1;
                        push.r1 = te_comma;
                        phase_next = PH_SKIP;
                        do_clear = 1'b1;
                    end else begin
                        pq_next = (inq_reg && is_quote) ? ~pq_reg : 1'b0;
                        if (is_quote) begin
                            inq_next = ~inq_reg;
                            aq_next = 1'b1;
                        end
                    end
                end
            end
        end

        if (do_clear) begin
            inq_next = 1'b0;
            pq_next  = 1'b0;
            aq_next  = 1'b0;
            cnt_next = '0;
            kwl_next = 4'hF;
        end

        if (push.v1) begin
            push.r1.last_of_run = 1'b1;
        end else if (push.v0) begin
            push.r0.last_of_run = 1'b1;
        end

        if (!step) begin
            push.v0 = 1'b0;
            push.v1 = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_SKIP;
            inq_reg   <= 1'b0;
            pq_reg    <= 1'b0;
            aq_reg    <= 1'b0;
            cnt_reg   <= '0;
            kwl_reg   <= 4'hF;
        end else if (step) begin
            phase_reg <= phase_next;
            inq_reg   <= inq_next;
            pq_reg    <= pq_next;
            aq_reg    <= aq_next;
            cnt_reg   <= cnt_next;
            kwl_reg   <= kwl_next;
        end
    end

endmodule

>>> sv/clt_result_fifo.sv
// Four-entry result queue: takes up to two results per cycle, gives one.
// Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_result_fifo
    import clt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output logic    room,
    output logic    not_empty,
    output result_t head
);

    localparam int DEPTH = 4;

    result_t    entries_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_push;
    logic       do_pop;

    assign not_empty = (count_reg != 3'd0);
    assign room      = (count_reg <= 3'd2);
    assign head      = entries_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        n_push = {1'b0, push.v0} + {1'b0, push.v1};
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
        count_next = count_reg + {1'b0, n_push} - {2'b00, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.v0) begin
            entries_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            entries_reg[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/config_line_tokenizer.sv
// Top level of the config line tokenizer: input register, step core, result queue.
// Depends on clt_pkg, clt_if, clt_core and clt_result_fifo.
`timescale 1ns / 1ps

// Splits a byte stream into configuration tokens. One byte is taken per clock
// on the stream channel unless the input stalls; it is held in an input
// register and then processed by the step core, which pushes zero, one or two
// results into a four-entry result queue. The token channel drains that queue
// at one result per clock while the receiver is ready, so the sustained rate
// is one byte per cycle for bytes that produce at most one result. A byte that
// produces two results (a newline closing a token, an unquoted comma, stream
// end after a pending token) puts both into the queue; the queue absorbs short
// bursts of these and the input stalls only when the queue holds more than two
// results. Every result of a byte carries last_of_run on its final entry;
// stream end returns all state to its reset value. TOKEN_BUFFER sets the
// length limit (TOKEN_BUFFER - 2 stored characters) and the width of the
// character counter.

module config_line_tokenizer
    import clt_pkg::*;
#(
    parameter int TOKEN_BUFFER = TOKEN_BUFFER_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    clt_in_if.sink   stream,
    clt_out_if.source tokens
);

    // input register
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       end_reg;

    logic    room;
    logic    step;
    logic    not_empty;
    push_t   push;
    result_t head;

    // a held byte is processed once the queue can take two results
    assign step = in_valid_reg && room;
    assign stream.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (stream.ready) begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready) begin
            char_reg <= stream.char_in;
            end_reg  <= stream.stream_end;
        end
    end

    clt_core #(
        .TOKEN_BUFFER (TOKEN_BUFFER)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .char_in    (char_reg),
        .stream_end (end_reg),
        .push       (push)
    );

    clt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (tokens.ready),
        .room      (room),
        .not_empty (not_empty),
        .head      (head)
    );

    // result transfer side
    assign tokens.valid        = not_empty;
    assign tokens.result_kind  = head.kind;
    assign tokens.char_out     = head.char_out;
    assign tokens.token_length = head.token_length;
    assign tokens.keyword_code = head.keyword_code;
    assign tokens.was_quoted   = head.was_quoted;
    assign tokens.overflowed   = head.overflowed;
    assign tokens.last_of_run  = head.last_of_run;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for config_line_tokenizer: byte stream in, token results out.
// Depends on clt_pkg, clt_if and the config_line_tokenizer RTL.
`timescale 1ns / 1ps

module tb_top;
    import clt_pkg::*;

    // Run length and idle profile
    localparam int          STREAM_BYTES  = 1450;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          MODE_SPAN     = 150;    // transfers per idle mode
    localparam int          MODE_STEADY   = 0;
    localparam int          MODE_SRC_GAPS = 1;
    localparam int          MODE_SNK_STALL = 2;
    localparam int          MODE_BOTH     = 3;
    localparam int          HOLD_START    = 60;     // transfers before the long stall
    localparam int          HOLD_CYCLES   = 100;
    localparam int          DRAIN_INDEX   = 800;    // sender waits for an empty pipe here
    localparam int unsigned TOKEN_LIMIT   = TOKEN_BUFFER_DEFAULT - 2;
    localparam int          REPORT_MAX    = 10;

    localparam logic [2:0] KW_CODES [4] = '{KW_ALL, KW_SAMEUSER, KW_SAMEGROUP, KW_SAMEROLE};
    string kw_words [4] = '{"all", "sameuser", "samegroup", "samerole"};

    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
        logic       drain;   // hold this byte back until all results are in
    } stim_t;

    logic clk;
    logic rst_n;

    clt_in_if  in_ch ();
    clt_out_if out_ch ();

    config_line_tokenizer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (in_ch),
        .tokens (out_ch)
    );

    // Stimulus and scoreboard storage
    stim_t   byte_queue [$];
    result_t pending_results [$];

    // Tokenizer shadow state
    phase_t      tk_phase;
    logic        tk_in_quotes;
    logic        tk_quote_pair;
    logic        tk_quoted;
    int unsigned tk_count;
    logic [3:0]  tk_live;
    result_t     step_buf [2];
    int          step_n;

    // Bookkeeping
    int sent_count    = 0;
    int hold_left     = 0;
    bit hold_done     = 0;
    int errors        = 0;
    int results_seen  = 0;
    int tokens_seen   = 0;
    int keywords_seen = 0;
    int overflow_seen = 0;
    int eof_seen      = 0;
    int cycle_count   = 0;

    //------------------------------------------------------------------------
    // Tokenizer prediction
    //------------------------------------------------------------------------

    function automatic void clear_token();
        tk_in_quotes  = 1'b0;
        tk_quote_pair = 1'b0;
        tk_quoted     = 1'b0;
        tk_count      = 0;
        tk_live       = 4'hF;
    endfunction

    function automatic void note_result(result_kind_t kind, logic [7:0] ch, int unsigned len,
                                        logic [2:0] kw, logic quoted, logic ov);
        result_t r;
        r.kind         = kind;
        r.char_out     = ch;
        r.token_length = (len > 255) ? 8'hFF : 8'(len);
        r.keyword_code = kw;
        r.was_quoted   = quoted;
        r.overflowed   = ov;
        r.last_of_run  = 1'b0;
        step_buf[step_n] = r;
        step_n++;
    endfunction

    // Token end: keyword match only for unquoted tokens whose full text matched
    function automatic void close_token(logic ov);
        logic [2:0] kw;
        kw = KW_NONE;
        if (!tk_quoted) begin
            for (int k = 0; k < 4; k++) begin
                if (kw == KW_NONE && tk_live[k] && tk_count == kw_words[k].len())
                    kw = KW_CODES[k];
            end
        end
        note_result(KIND_TOKEN_END, 8'h00, tk_count, kw, tk_quoted, ov);
        clear_token();
    endfunction

    function automatic void track_keywords(logic [7:0] c);
        for (int k = 0; k < 4; k++) begin
            if (tk_count >= kw_words[k].len() || kw_words[k][tk_count] != c)
                tk_live[k] = 1'b0;
        end
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR;
    endfunction

    function automatic void token_char(logic [7:0] c);
        if (c == CH_NL) begin
            close_token(1'b0);
            tk_phase = PH_SKIP;
            note_result(KIND_LINE_END, 8'h00, 0, KW_NONE, 1'b0, 1'b0);
            return;
        end
        if (is_blank(c) && !tk_in_quotes) begin
            tk_phase = PH_SKIP;
            close_token(1'b0);
            return;
        end
        if (c == CH_HASH && !tk_in_quotes) begin
            if (tk_count > 0) begin
                tk_phase = PH_DROP;
                close_token(1'b0);
            end
            else
                tk_phase = PH_LEAD_COMMENT;
            return;
        end
        if (tk_count >= TOKEN_LIMIT) begin
            tk_phase = PH_DROP;
            close_token(1'b1);
            return;
        end
        // an opening quote is not stored; the second of a pair is
        if (c != CH_QUOTE || tk_quote_pair) begin
            track_keywords(c);
            tk_count++;
            note_result(KIND_CHAR, c, 0, KW_NONE, 1'b0, 1'b0);
        end
        if (c == CH_COMMA && !tk_in_quotes) begin
            tk_phase = PH_SKIP;
            close_token(1'b0);
            return;
        end
        tk_quote_pair = (tk_in_quotes && c == CH_QUOTE) ? ~tk_quote_pair : 1'b0;
        if (c == CH_QUOTE) begin
            tk_in_quotes = ~tk_in_quotes;
            tk_quoted    = 1'b1;
        end
    endfunction

    // One accepted byte: work out its results and queue them
    function automatic void tokenize_step(logic [7:0] c, logic eof);
        result_t r;
        step_n = 0;
        if (eof) begin
            if (tk_phase == PH_TOKEN || (tk_phase == PH_LEAD_COMMENT && tk_quoted))
                close_token(1'b0);
            note_result(KIND_STREAM_END, 8'h00, 0, KW_NONE, 1'b0, 1'b0);
            tk_phase = PH_SKIP;
            clear_token();
        end
        else begin
            case (tk_phase)
                PH_SKIP: begin
                    if (c == CH_NL)
                        note_result(KIND_LINE_END, 8'h00, 0, KW_NONE, 1'b0, 1'b0);
                    else if (!is_blank(c) && c != CH_COMMA) begin
                        tk_phase = PH_TOKEN;
                        token_char(c);
                    end
                end
                PH_TOKEN: token_char(c);
                PH_DROP: begin
                    if (c == CH_NL) begin
                        tk_phase = PH_SKIP;
                        clear_token();
                        note_result(KIND_LINE_END, 8'h00, 0, KW_NONE, 1'b0, 1'b0);
                    end
                end
                default: begin
                    // comment with nothing stored; a quoted empty token still ends here
                    if (c == CH_NL) begin
                        if (tk_quoted)
                            close_token(1'b0);
                        else
                            note_result(KIND_LINE_END, 8'h00, 0, KW_NONE, 1'b0, 1'b0);
                        clear_token();
                        tk_phase = PH_SKIP;
                    end
                end
            endcase
        end
        for (int i = 0; i < step_n; i++) begin
            r = step_buf[i];
            r.last_of_run = (i == step_n - 1);
            pending_results.push_back(r);
        end
    endfunction

    //------------------------------------------------------------------------
    // Stimulus building
    //------------------------------------------------------------------------

    function automatic void add_byte(logic [7:0] c);
        stim_t s;
        s.ch    = c;
        s.eof   = 1'b0;
        s.drain = (byte_queue.size() == DRAIN_INDEX);
        byte_queue.push_back(s);
    endfunction

    function automatic void add_eof();
        stim_t s;
        s.ch    = 8'($urandom_range(0, 255));   // ignored by the block
        s.eof   = 1'b1;
        s.drain = (byte_queue.size() == DRAIN_INDEX);
        byte_queue.push_back(s);
    endfunction

    function automatic void add_text(string t);
        for (int i = 0; i < t.len(); i++)
            add_byte(t[i]);
    endfunction

    // Printable byte with no special meaning
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 126));
        while (c == CH_QUOTE || c == CH_HASH || c == CH_COMMA);
        return c;
    endfunction

    function automatic void add_separators(int most);
        repeat ($urandom_range(0, most)) begin
            case ($urandom_range(0, 3))
                0: add_byte(CH_SPACE);
                1: add_byte(CH_TAB);
                2: add_byte(CH_CR);
                default: add_byte(CH_COMMA);
            endcase
        end
    endfunction

    function automatic void add_quoted();
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
                0: add_byte(CH_SPACE);
                1: add_byte(CH_HASH);
                2: add_byte(CH_COMMA);
                3: begin
                    add_byte(CH_QUOTE);
                    add_byte(CH_QUOTE);
                end
                default: add_byte(word_char());
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            add_byte(CH_QUOTE);
        if ($urandom_range(0, 3) == 0)
            add_byte(word_char());
    endfunction

    function automatic void add_token();
        string w;
        w = kw_words[$urandom_range(0, 3)];
        case ($urandom_range(0, 9))
            0, 1: add_text(w);
            2: add_text(w.substr(0, $urandom_range(0, w.len() - 2)));    // prefix only
            3: begin
                add_text(w);
                add_byte(word_char());
            end
            4, 5: repeat ($urandom_range(1, 8)) add_byte(word_char());
            6, 7: add_quoted();
            8: begin
                // raw noise, any byte value
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                add_byte(CH_QUOTE);
                add_text(w);
                add_byte(CH_QUOTE);
            end
        endcase
    endfunction

    function automatic void add_line();
        repeat ($urandom_range(0, 4)) begin
            add_separators(2);
            add_token();
        end
        add_separators(2);
        if ($urandom_range(0, 4) == 0) begin
            add_byte(CH_HASH);
            repeat ($urandom_range(0, 4))
                add_byte(($urandom_range(0, 3) == 0) ? CH_QUOTE : word_char());
        end
        case ($urandom_range(0, 99)) inside
            [0:84]:  add_byte(CH_NL);
            [85:92]: add_eof();
            default: ;          // runs on into the next line
        endcase
    endfunction

    //------------------------------------------------------------------------
    // Idle profile
    //------------------------------------------------------------------------

    function automatic int idle_mode();
        return (sent_count / MODE_SPAN) % 4;
    endfunction

    function automatic bit sender_gap();
        case (idle_mode())
            MODE_SRC_GAPS: return $urandom_range(0, 99) < 57;
            MODE_BOTH:     return $urandom_range(0, 99) < 37;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode())
            MODE_SNK_STALL: return $urandom_range(0, 99) < 57;
            MODE_BOTH:      return $urandom_range(0, 99) < 37;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic string show(result_t r);
        return $sformatf("kind=%0d ch=%02h len=%0d kw=%0d q=%0b ov=%0b last=%0b",
                         r.kind, r.char_out, r.token_length, r.keyword_code,
                         r.was_quoted, r.overflowed, r.last_of_run);
    endfunction

    function automatic void flag_error(string what, string detail);
        if (errors < REPORT_MAX)
            $display("[%0t] ERROR %s: %s", $realtime, what, detail);
        errors++;
    endfunction

    //------------------------------------------------------------------------
    // Clock
    //------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    //------------------------------------------------------------------------
    // Driver: offers the next byte on a free input slot, bar idle gaps or drain.
    // A byte stays on the bus, unchanged, until its transfer.
    //------------------------------------------------------------------------

    always @(posedge clk)
    begin
        stim_t nxt;
        bit    go;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                tokenize_step(in_ch.char_in, in_ch.stream_end);
                sent_count <= sent_count + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                go = byte_queue.size() != 0 && !sender_gap();
                // drain point: nothing new until every result is back
                if (go && byte_queue[0].drain && pending_results.size() != 0)
                    go = 1'b0;
                if (go) begin
                    nxt = byte_queue.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.char_in    <= nxt.ch;
                    in_ch.stream_end <= nxt.eof;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------------
    // Long receiver hold-off. Fires once early, in the steady phase, while the
    // driver keeps offering bytes, so the result queue fills and the input
    // stalls.
    //------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && !hold_done && sent_count >= HOLD_START) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    //------------------------------------------------------------------------
    // Monitor: every result transfer is checked against the oldest prediction
    //------------------------------------------------------------------------

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.kind         = result_kind_t'(out_ch.result_kind);
                got.char_out     = out_ch.char_out;
                got.token_length = out_ch.token_length;
                got.keyword_code = out_ch.keyword_code;
                got.was_quoted   = out_ch.was_quoted;
                got.overflowed   = out_ch.overflowed;
                got.last_of_run  = out_ch.last_of_run;
                results_seen++;
                if (pending_results.size() == 0)
                    flag_error("unexpected result", show(got));
                else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.char_out !== want.char_out ||
                        got.token_length !== want.token_length ||
                        got.keyword_code !== want.keyword_code ||
                        got.was_quoted !== want.was_quoted ||
                        got.overflowed !== want.overflowed ||
                        got.last_of_run !== want.last_of_run)
                        flag_error("mismatch",
                                   {"expected ", show(want), " got ", show(got)});
                    if (want.kind == KIND_TOKEN_END) begin
                        tokens_seen++;
                        if (want.keyword_code != KW_NONE)
                            keywords_seen++;
                        if (want.overflowed)
                            overflow_seen++;
                    end
                    if (want.kind == KIND_STREAM_END)
                        eof_seen++;
                end
            end
            out_ch.ready <= (hold_left == 0) && !receiver_stall();
        end
    end

    //------------------------------------------------------------------------
    // Watchdog
    //------------------------------------------------------------------------

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still outstanding",
                 cycle_count, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    //------------------------------------------------------------------------
    // Main sequence: build the stream, reset, wait for the drain, report
    //------------------------------------------------------------------------

    initial
    begin
        bit long_done;
        bit over_done;
        long_done = 1'b0;
        over_done = 1'b0;

        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.char_in    = 8'h00;
        in_ch.stream_end = 1'b0;
        out_ch.ready     = 1'b0;
        tk_phase         = PH_SKIP;
        clear_token();

        // Directed opener: keyword ended by a tab, doubled quote inside quotes
        // with an unquoted comma after, comment right after stored text,
        // quoted empty token before a comment, bare comment line, NUL and
        // 0xFF stored as plain bytes, stream end closing a pending token.
        add_text("all\t\"a\"\"b\",x#c\n\"\"#\n#\n");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_eof();

        // Random lines, plus one token exactly at the length limit and one
        // that overflows it with junk after the cut.
        while (byte_queue.size() < STREAM_BYTES) begin
            if (!long_done && byte_queue.size() > 400) begin
                repeat (TOKEN_LIMIT) add_byte(word_char());
                add_byte(CH_NL);
                long_done = 1'b1;
            end
            if (!over_done && byte_queue.size() > 900) begin
                repeat (TOKEN_LIMIT + 3) add_byte(word_char());
                add_text(" tail,\"#x\n");
                over_done = 1'b1;
            end
            add_line();
        end
        add_text("samerole");
        add_eof();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || in_ch.valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        while (pending_results.size() != 0)
            flag_error("missing result", show(pending_results.pop_front()));

        $display("Sent %0d bytes over four idle profiles, checked %0d results",
                 sent_count, results_seen);
        $display("Token ends %0d (keywords %0d, overflows %0d), stream ends %0d, errors %0d",
                 tokens_seen, keywords_seen, overflow_seen, eof_seen, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
